/* rtl/ecw_pkg.sv */
// Shared types and constants for the Euler circuit walk block.
// Used by ecw_adj and euler_circuit_walk_core; depends on nothing else.
`default_nettype none

package ecw_pkg;

  // Width of a vertex number on the stream ports and in the stores.
  localparam int VERTEX_W = 3;
  // Byte-padded width of the stream data buses.
  localparam int TDATA_W = 8;

  // Walk sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_POP,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  // Operations on the adjacency matrix.
  typedef enum logic [1:0] {
    ADJ_NOP,
    ADJ_ADD,
    ADJ_TAKE
  } adj_op_t;

  // Command into the adjacency unit; a also selects the row that is scanned.
  typedef struct packed {
    adj_op_t               op;
    logic [VERTEX_W-1:0]   a;
    logic [VERTEX_W-1:0]   b;
  } adj_cmd_t;

  // Status from the adjacency unit.
  typedef struct packed {
    logic                  found;
    logic [VERTEX_W-1:0]   nb;
    logic                  edges_left;
  } adj_stat_t;

endpackage

`default_nettype wire

/* rtl/euler_circuit_walk_core.sv */
// Euler circuit walk: an add-edge beat gives no result. A run beat walks the graph,
// pushing a vertex for each edge taken and popping dead ends into the circuit store,
// then emits the circuit; every pop but the final one and every result emitted goes
// through a registered read of the single-port walk stack or circuit store.
// Reset is synchronous: it clears the graph, the sequencer and the output valid;
// the stack and circuit store are not cleared and are only read after being written.
`default_nettype none

module euler_circuit_walk_core #(
  parameter int VERTICES    = 8,
  parameter int STACK_DEPTH = 32
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  // [2:0] first_vertex, [5:3] second_vertex, [7:6] zero
  input  wire  [ecw_pkg::TDATA_W-1:0]     s_axis_tdata,
  // [0] kind
  input  wire                             s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  // [2:0] vertex, [7:3] zero
  output logic [ecw_pkg::TDATA_W-1:0]     m_axis_tdata,
  output logic                            m_axis_tlast,
  // [0] edges_left
  output logic                            m_axis_tuser
);

  localparam int VTW = ecw_pkg::VERTEX_W;
  localparam int DW  = $clog2(STACK_DEPTH + 1);
  localparam int IW  = $clog2(STACK_DEPTH);

  ecw_pkg::state_t    state;
  ecw_pkg::state_t    state_next;
  ecw_pkg::adj_cmd_t  cmd;
  ecw_pkg::adj_stat_t stat;

  logic [VTW-1:0] walk_stack [STACK_DEPTH];
  logic [VTW-1:0] circuit_store [STACK_DEPTH];
  logic [VTW-1:0] stack_rd;
  logic [VTW-1:0] store_rd;

  logic [DW-1:0]  depth;
  logic [DW-1:0]  clen;
  logic [VTW-1:0] top;
  logic [IW-1:0]  idx;

  logic           in_beat;
  logic           can_push;
  logic           out_free;
  logic           stack_we;
  logic [IW-1:0]  stack_wa;
  logic [VTW-1:0] stack_wd;
  logic           stack_re;
  logic           store_we;
  logic           store_re;
  logic           out_load;

  assign s_axis_tready = (state == ecw_pkg::ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign can_push      = stat.found && (depth < DW'(STACK_DEPTH));

  ecw_adj #(
    .VERTICES(VERTICES)
  ) u_adj (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  // Next state of the walk sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ecw_pkg::ST_IDLE: begin
        if (in_beat && s_axis_tuser) state_next = ecw_pkg::ST_WALK;
      end
      ecw_pkg::ST_WALK: begin
        if (can_push) begin
          state_next = ecw_pkg::ST_WALK;
        end else if (depth == DW'(1)) begin
          state_next = ecw_pkg::ST_EMIT_RD;
        end else begin
          state_next = ecw_pkg::ST_POP;
        end
      end
      ecw_pkg::ST_POP:     state_next = ecw_pkg::ST_WALK;
      ecw_pkg::ST_EMIT_RD: state_next = ecw_pkg::ST_EMIT_LD;
      ecw_pkg::ST_EMIT_LD: begin
        if (out_free) begin
          state_next = (idx == '0) ? ecw_pkg::ST_IDLE : ecw_pkg::ST_EMIT_RD;
        end
      end
      default: state_next = ecw_pkg::ST_IDLE;
    endcase
  end

  // Per-state control of the adjacency unit, stores and output register.
  always_comb begin
    cmd.op   = ecw_pkg::ADJ_NOP;
    cmd.a    = top;
    cmd.b    = s_axis_tdata[2*VTW-1:VTW];
    stack_we = 1'b0;
    stack_wa = IW'(depth);
    stack_wd = stat.nb;
    stack_re = 1'b0;
    store_we = 1'b0;
    store_re = 1'b0;
    out_load = 1'b0;
    case (state)
      ecw_pkg::ST_IDLE: begin
        cmd.a    = s_axis_tdata[VTW-1:0];
        stack_wa = '0;
        stack_wd = s_axis_tdata[VTW-1:0];
        if (in_beat && !s_axis_tuser) cmd.op = ecw_pkg::ADJ_ADD;
        if (in_beat && s_axis_tuser)  stack_we = 1'b1;
      end
      ecw_pkg::ST_WALK: begin
        if (can_push) begin
          cmd.op   = ecw_pkg::ADJ_TAKE;
          stack_we = 1'b1;
        end else begin
          store_we = (clen < DW'(STACK_DEPTH));
          stack_re = (depth != DW'(1));
        end
      end
      ecw_pkg::ST_EMIT_RD: store_re = 1'b1;
      ecw_pkg::ST_EMIT_LD: out_load = out_free;
      default: ;
    endcase
  end

  // Walk stack: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (stack_we) walk_stack[stack_wa] <= stack_wd;
  end

  always_ff @(posedge clk) begin
    if (stack_re) stack_rd <= walk_stack[IW'(depth - DW'(2))];
  end

  // Circuit store: dead-end vertices in pop order, read back in reverse.
  always_ff @(posedge clk) begin
    if (store_we) circuit_store[IW'(clen)] <= top;
  end

  always_ff @(posedge clk) begin
    if (store_re) store_rd <= circuit_store[idx];
  end

  // Sequencer state and walk counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ecw_pkg::ST_IDLE;
      depth <= '0;
      clen  <= '0;
    end else begin
      state <= state_next;
      case (state)
        ecw_pkg::ST_IDLE: begin
          if (in_beat && s_axis_tuser) begin
            depth <= DW'(1);
            clen  <= '0;
          end
        end
        ecw_pkg::ST_WALK: begin
          if (can_push) begin
            depth <= depth + DW'(1);
          end else begin
            depth <= depth - DW'(1);
            if (store_we) clen <= clen + DW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Top-of-stack vertex and the emit index.
  always_ff @(posedge clk) begin
    case (state)
      ecw_pkg::ST_IDLE: begin
        if (in_beat && s_axis_tuser) top <= s_axis_tdata[VTW-1:0];
      end
      ecw_pkg::ST_WALK: begin
        if (can_push) begin
          top <= stat.nb;
        end else if (depth == DW'(1)) begin
          idx <= store_we ? IW'(clen) : IW'(clen - DW'(1));
        end
      end
      ecw_pkg::ST_POP: top <= stack_rd;
      ecw_pkg::ST_EMIT_LD: begin
        if (out_free && (idx != '0)) idx <= idx - IW'(1);
      end
      default: ;
    endcase
  end

  // Output register: holds a result beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= ecw_pkg::TDATA_W'(store_rd);
      m_axis_tlast <= (idx == '0);
      m_axis_tuser <= (idx == '0) && stat.edges_left;
    end
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(STACK_DEPTH))
    else $error("walk stack depth beyond its size");

  a_clen_bound: assert property (@(posedge clk) disable iff (rst)
    clen <= DW'(STACK_DEPTH))
    else $error("circuit length beyond the store size");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ecw_pkg::ST_WALK || state == ecw_pkg::ST_POP) |-> (depth != '0))
    else $error("walking with an empty stack");

  a_flag_on_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("edges_left flag on a beat that is not last");

  a_run_ends_last: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == ecw_pkg::ST_EMIT_LD && state == ecw_pkg::ST_IDLE) |->
      (m_axis_tvalid && m_axis_tlast))
    else $error("run finished without a last beat");
`endif

endmodule

`default_nettype wire

/* rtl/ecw_adj.sv */
// Adjacency bit matrix with its lowest-neighbor scan and an edge counter.
// Depends on ecw_pkg for the command and status types.
`default_nettype none

module ecw_adj #(
  parameter int VERTICES = 8
) (
  input  wire              clk,
  input  wire              rst,
  input  ecw_pkg::adj_cmd_t cmd,
  output ecw_pkg::adj_stat_t stat
);

  localparam int VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int EW = $clog2(VERTICES * (VERTICES - 1) / 2 + 1);

  logic [VERTICES-1:0] rows [VERTICES];
  logic [EW-1:0]       edge_cnt;

  logic                a_in_range;
  logic                b_in_range;
  logic [VW-1:0]       ai;
  logic [VW-1:0]       bi;
  logic [VW-1:0]       nbi;
  logic [VERTICES-1:0] row_rd;
  logic                found;
  logic [ecw_pkg::VERTEX_W-1:0] nb;
  logic                add_ok;
  logic                add_new;
  logic                take_ok;

  // Row select: the addressed vertex may lie beyond the graph.
  assign a_in_range = 32'(cmd.a) < VERTICES;
  assign b_in_range = 32'(cmd.b) < VERTICES;
  assign ai         = VW'(cmd.a);
  assign bi         = VW'(cmd.b);
  assign row_rd     = a_in_range ? rows[ai] : '0;

  // Lowest set bit of the selected row.
  always_comb begin
    found = 1'b0;
    nb    = '0;
    for (int k = VERTICES - 1; k >= 0; k--) begin
      if (row_rd[k]) begin
        found = 1'b1;
        nb    = ecw_pkg::VERTEX_W'(k);
      end
    end
  end

  assign nbi     = VW'(nb);
  assign add_ok  = (cmd.op == ecw_pkg::ADJ_ADD) && a_in_range && b_in_range &&
                   (cmd.a != cmd.b);
  assign add_new = add_ok && !row_rd[bi];
  assign take_ok = (cmd.op == ecw_pkg::ADJ_TAKE) && found;

  // Matrix update: an add sets both mirror bits, a take clears both.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < VERTICES; r++) begin
        rows[r] <= '0;
      end
    end else begin
      if (add_ok) begin
        rows[ai][bi] <= 1'b1;
        rows[bi][ai] <= 1'b1;
      end
      if (take_ok) begin
        rows[ai][nbi] <= 1'b0;
        rows[nbi][ai] <= 1'b0;
      end
    end
  end

  // The edge count stands in for an OR over the whole matrix.
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_cnt <= '0;
    end else if (add_new) begin
      edge_cnt <= edge_cnt + EW'(1);
    end else if (take_ok) begin
      edge_cnt <= edge_cnt - EW'(1);
    end
  end

  assign stat.found      = found;
  assign stat.nb         = nb;
  assign stat.edges_left = (edge_cnt != '0);

endmodule

`default_nettype wire
